/* design/dagadj_pkg.sv */
// Shared constants, operation codes, sequencer states and node entry layout.
package dagadj_pkg;

  localparam int NODE_SLOTS = 32;
  localparam int RANK_W     = $clog2(NODE_SLOTS);
  localparam int EDGE_SLOTS = NODE_SLOTS * (NODE_SLOTS - 1) / 2;
  localparam int PID_W      = 22;
  localparam int OPID_W     = PID_W + 1;
  localparam int CNT_W      = 5;
  localparam int NTOT_W     = 6;
  localparam int ETOT_W     = 9;

  typedef enum logic [2:0] {
    OP_ADD_NODE = 3'd0,
    OP_DEL_NODE = 3'd1,
    OP_ADD_EDGE = 3'd2,
    OP_DEL_EDGE = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_WR_A,
    S_ROW,
    S_WALK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CNT_W-1:0] parents;
    logic [CNT_W-1:0] children;
  } node_ent_t;

endpackage

/* design/dag_adjacency_degree_table.sv */
// Task graph node/edge table with degree counts, held in a node memory and an edge-row memory.
// Path, accepted beat to result beat: clear all goes straight to S_OUT; add node, unused mode
// and rejected edge pass S_RD_A; add/remove edge pass S_RD_A, S_RD_B and S_WR_A (node memory
// has one read port, so both end slots are read and written in turn); remove node passes
// S_ROW and then S_WALK, one slot per cycle. A new beat is taken the cycle after its result
// is registered. Reset (synchronous) and clear all zero the valid bits and totals.
module dag_adjacency_degree_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [2:0]                          mode,
  input  logic [dagadj_pkg::RANK_W-1:0]       first_rank,
  input  logic [dagadj_pkg::RANK_W-1:0]       second_rank,
  input  logic [dagadj_pkg::PID_W-1:0]        node_pid,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                status,
  output logic [dagadj_pkg::NTOT_W-1:0]       node_total,
  output logic [dagadj_pkg::ETOT_W-1:0]       edge_total,
  output logic [dagadj_pkg::CNT_W-1:0]        first_parents,
  output logic [dagadj_pkg::CNT_W-1:0]        first_children,
  output logic signed [dagadj_pkg::OPID_W-1:0] first_pid
);

  localparam logic [dagadj_pkg::RANK_W-1:0] LAST_SLOT =
    dagadj_pkg::RANK_W'(dagadj_pkg::NODE_SLOTS - 1);
  localparam logic [dagadj_pkg::NODE_SLOTS-1:0] BIT0 = dagadj_pkg::NODE_SLOTS'(1);

  dagadj_pkg::state_t state, state_next;

  // latched command
  dagadj_pkg::op_t                   op;
  logic [dagadj_pkg::RANK_W-1:0]     ra, rb;
  logic [dagadj_pkg::PID_W-1:0]      rpid;

  // per-slot valid bits; row_valid gates the edge rows
  logic [dagadj_pkg::NODE_SLOTS-1:0] node_valid, pid_set, row_valid;
  logic [dagadj_pkg::NTOT_W-1:0]     nodes;
  logic [dagadj_pkg::ETOT_W-1:0]     edges;

  // memories: node entries, and one row per lower slot with a bit per higher slot
  dagadj_pkg::node_ent_t             node_mem [dagadj_pkg::NODE_SLOTS];
  dagadj_pkg::node_ent_t             node_rdata;
  logic [dagadj_pkg::NODE_SLOTS-1:0] edge_mem [dagadj_pkg::NODE_SLOTS];
  logic [dagadj_pkg::NODE_SLOTS-1:0] edge_rdata;

  logic [dagadj_pkg::RANK_W-1:0]     node_raddr, node_waddr, edge_raddr, edge_waddr;
  logic                              node_we, edge_we;
  dagadj_pkg::node_ent_t             node_wdata;
  logic [dagadj_pkg::NODE_SLOTS-1:0] edge_wdata;

  // working registers
  dagadj_pkg::node_ent_t             ent_a;
  logic [dagadj_pkg::NODE_SLOTS-1:0] row_a, srow;
  logic [dagadj_pkg::RANK_W-1:0]     idx;
  logic                              hold_status;
  logic [dagadj_pkg::CNT_W-1:0]      hold_parents, hold_children;
  logic signed [dagadj_pkg::OPID_W-1:0] hold_pid;

  // combinational
  logic [dagadj_pkg::RANK_W-1:0]     cur;
  dagadj_pkg::node_ent_t             cur_ent, new_a, new_b, walk_ent;
  logic [dagadj_pkg::NODE_SLOTS-1:0] cur_row;
  logic signed [dagadj_pkg::OPID_W-1:0] cur_pid;
  logic                              is_edge_op, reject, edge_hit, walk_hit;
  logic                              walk_lower, walk_higher;
  logic                              edge_inc, edge_dec, out_load;

  assign is_edge_op = (op == dagadj_pkg::OP_ADD_EDGE) || (op == dagadj_pkg::OP_DEL_EDGE);
  assign reject     = is_edge_op && !(ra < rb);
  assign edge_hit   = row_a[rb];
  assign walk_lower  = idx < ra;
  assign walk_higher = idx > ra;
  assign out_load   = !res_valid || !res_stall;

  // slot whose data sits on the read ports this cycle; counts of invalid slots read as zero
  always_comb begin
    case (state)
      dagadj_pkg::S_RD_B: cur = rb;
      dagadj_pkg::S_WALK: cur = idx;
      default:            cur = ra;
    endcase
    cur_ent = node_rdata;
    if (!node_valid[cur]) begin
      cur_ent.parents  = '0;
      cur_ent.children = '0;
    end
    cur_row = row_valid[cur] ? edge_rdata : '0;
    cur_pid = pid_set[cur] ? $signed({1'b0, node_rdata.pid}) : '1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dagadj_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd_stall   = (state != dagadj_pkg::S_IDLE);
    node_raddr  = ra;
    edge_raddr  = ra;
    node_we     = 1'b0;
    node_waddr  = cur;
    node_wdata  = cur_ent;
    edge_we     = 1'b0;
    edge_waddr  = cur;
    edge_wdata  = cur_row;
    new_a       = ent_a;
    new_b       = cur_ent;
    walk_ent    = cur_ent;
    walk_hit    = 1'b0;
    edge_inc    = 1'b0;
    edge_dec    = 1'b0;
    case (state)
      dagadj_pkg::S_IDLE: begin
        node_raddr = first_rank;
        edge_raddr = first_rank;
        if (cmd_valid) begin
          case (dagadj_pkg::op_t'(mode))
            dagadj_pkg::OP_CLEAR:    state_next = dagadj_pkg::S_OUT;
            dagadj_pkg::OP_DEL_NODE: state_next = dagadj_pkg::S_ROW;
            default:                 state_next = dagadj_pkg::S_RD_A;
          endcase
        end
      end
      dagadj_pkg::S_RD_A: begin
        state_next = dagadj_pkg::S_OUT;
        case (op)
          dagadj_pkg::OP_ADD_NODE: begin
            node_we        = 1'b1;
            node_waddr     = ra;
            node_wdata     = cur_ent;
            node_wdata.pid = rpid;
          end
          dagadj_pkg::OP_ADD_EDGE, dagadj_pkg::OP_DEL_EDGE: begin
            if (!reject) begin
              node_raddr = rb;
              state_next = dagadj_pkg::S_RD_B;
            end
          end
          default: begin
          end
        endcase
      end
      dagadj_pkg::S_RD_B: begin
        if (op == dagadj_pkg::OP_ADD_EDGE) begin
          if (!edge_hit) begin
            new_a.children = ent_a.children + 1'b1;
            new_b.parents  = cur_ent.parents + 1'b1;
            edge_we        = 1'b1;
            edge_wdata     = row_a | (BIT0 << rb);
            edge_inc       = 1'b1;
          end
        end else if (edge_hit) begin
          edge_we    = 1'b1;
          edge_wdata = row_a & ~(BIT0 << rb);
          if (edges != '0) begin
            edge_dec = 1'b1;
            if (ent_a.children != '0) new_a.children = ent_a.children - 1'b1;
            if (cur_ent.parents != '0) new_b.parents = cur_ent.parents - 1'b1;
          end
        end
        edge_waddr = ra;
        node_we    = 1'b1;
        node_waddr = rb;
        node_wdata = new_b;
        state_next = dagadj_pkg::S_WR_A;
      end
      dagadj_pkg::S_WR_A: begin
        node_we    = 1'b1;
        node_waddr = ra;
        node_wdata = ent_a;
        state_next = dagadj_pkg::S_OUT;
      end
      dagadj_pkg::S_ROW: begin
        node_raddr = '0;
        edge_raddr = '0;
        state_next = dagadj_pkg::S_WALK;
      end
      dagadj_pkg::S_WALK: begin
        node_raddr = idx + 1'b1;
        edge_raddr = idx + 1'b1;
        // pair (idx, ra) lives in row idx when idx is lower, else in the saved row of ra
        if (walk_lower) begin
          walk_hit   = cur_row[ra];
          edge_we    = 1'b1;
          edge_waddr = idx;
          edge_wdata = cur_row & ~(BIT0 << ra);
        end else if (walk_higher) begin
          walk_hit = srow[idx];
        end
        if (walk_hit && (edges != '0)) begin
          edge_dec = 1'b1;
          if (walk_lower) begin
            if (cur_ent.children != '0) walk_ent.children = cur_ent.children - 1'b1;
          end else begin
            if (cur_ent.parents != '0) walk_ent.parents = cur_ent.parents - 1'b1;
          end
          node_we    = 1'b1;
          node_waddr = idx;
          node_wdata = walk_ent;
        end
        if (idx == LAST_SLOT) state_next = dagadj_pkg::S_OUT;
      end
      dagadj_pkg::S_OUT: begin
        if (out_load) state_next = dagadj_pkg::S_IDLE;
      end
      default: state_next = dagadj_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= '0;
      pid_set    <= '0;
      row_valid  <= '0;
      nodes      <= '0;
      edges      <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != dagadj_pkg::S_OUT)) res_valid <= 1'b0;
      if (edge_we) row_valid[edge_waddr] <= 1'b1;
      if (edge_inc) edges <= edges + 1'b1;
      if (edge_dec) edges <= edges - 1'b1;
      case (state)
        dagadj_pkg::S_IDLE: begin
          if (cmd_valid) begin
            op   <= dagadj_pkg::op_t'(mode);
            ra   <= first_rank;
            rb   <= second_rank;
            rpid <= node_pid;
            hold_status <= dagadj_pkg::ST_DONE;
            if (dagadj_pkg::op_t'(mode) == dagadj_pkg::OP_CLEAR) begin
              node_valid    <= '0;
              pid_set       <= '0;
              row_valid     <= '0;
              nodes         <= '0;
              edges         <= '0;
              hold_parents  <= '0;
              hold_children <= '0;
              hold_pid      <= '1;
            end
          end
        end
        dagadj_pkg::S_RD_A: begin
          ent_a         <= cur_ent;
          row_a         <= cur_row;
          hold_status   <= reject ? dagadj_pkg::ST_REJECT : dagadj_pkg::ST_DONE;
          hold_parents  <= cur_ent.parents;
          hold_children <= cur_ent.children;
          hold_pid      <= (op == dagadj_pkg::OP_ADD_NODE) ? $signed({1'b0, rpid}) : cur_pid;
          if (op == dagadj_pkg::OP_ADD_NODE) begin
            node_valid[ra] <= 1'b1;
            pid_set[ra]    <= 1'b1;
            if (!node_valid[ra]) nodes <= nodes + 1'b1;
          end
        end
        dagadj_pkg::S_RD_B: begin
          ent_a <= new_a;
          if (op == dagadj_pkg::OP_ADD_EDGE) begin
            node_valid[ra] <= 1'b1;
            node_valid[rb] <= 1'b1;
            nodes <= nodes + dagadj_pkg::NTOT_W'(!node_valid[ra])
                           + dagadj_pkg::NTOT_W'(!node_valid[rb]);
          end
        end
        dagadj_pkg::S_WR_A: begin
          hold_parents  <= ent_a.parents;
          hold_children <= ent_a.children;
          hold_pid      <= pid_set[ra] ? $signed({1'b0, ent_a.pid}) : '1;
        end
        dagadj_pkg::S_ROW: begin
          srow <= cur_row;
          idx  <= '0;
        end
        dagadj_pkg::S_WALK: begin
          idx <= idx + 1'b1;
          if (idx == ra) hold_pid <= cur_pid;
          if (idx == LAST_SLOT) begin
            node_valid[ra] <= 1'b0;
            row_valid[ra]  <= 1'b0;
            if (node_valid[ra] && (nodes != '0)) nodes <= nodes - 1'b1;
            hold_parents  <= '0;
            hold_children <= '0;
          end
        end
        dagadj_pkg::S_OUT: begin
          if (out_load) begin
            res_valid      <= 1'b1;
            status         <= hold_status;
            node_total     <= nodes;
            edge_total     <= edges;
            first_parents  <= hold_parents;
            first_children <= hold_children;
            first_pid      <= hold_pid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_node_total_matches: assert property (@(posedge clk) disable iff (rst)
    (state == dagadj_pkg::S_IDLE) |-> ($countones(node_valid) == int'(nodes)))
    else $error("node total disagrees with node valid bits");

  a_totals_in_range: assert property (@(posedge clk) disable iff (rst)
    (int'(nodes) <= dagadj_pkg::NODE_SLOTS) && (int'(edges) <= dagadj_pkg::EDGE_SLOTS))
    else $error("node or edge total out of range");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && (mode == dagadj_pkg::OP_CLEAR))
    |=> (node_valid == '0) && (row_valid == '0) && (nodes == '0) && (edges == '0))
    else $error("clear all left state behind");

  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (state == dagadj_pkg::S_WALK) && (idx != LAST_SLOT)
    |=> (state == dagadj_pkg::S_WALK) && (idx == $past(idx) + 1'b1))
    else $error("slot walk skipped or left early");

  a_walk_one_edge_write: assert property (@(posedge clk) disable iff (rst)
    (state == dagadj_pkg::S_WALK) && edge_we |-> (edge_waddr < ra))
    else $error("slot walk wrote an edge row at or above the removed slot");

endmodule

/* verif/dag_adjacency_degree_table_tb.sv */
// Self-checking testbench for the task graph node/edge degree table.
`timescale 1ns / 100ps

module dag_adjacency_degree_table_tb;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int MIX_CMDS       = 827;
  localparam int CALM_TAIL      = 120;
  localparam int DRAIN_CYCLES   = 2 * (dagadj_pkg::NODE_SLOTS + 2) + 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 30;

  typedef struct packed {
    logic [2:0]                    mode;
    logic [dagadj_pkg::RANK_W-1:0] first_rank;
    logic [dagadj_pkg::RANK_W-1:0] second_rank;
    logic [dagadj_pkg::PID_W-1:0]  pid;
  } graph_cmd_t;

  typedef struct packed {
    logic                                 status;
    logic [dagadj_pkg::NTOT_W-1:0]        node_total;
    logic [dagadj_pkg::ETOT_W-1:0]        edge_total;
    logic [dagadj_pkg::CNT_W-1:0]         first_parents;
    logic [dagadj_pkg::CNT_W-1:0]         first_children;
    logic signed [dagadj_pkg::OPID_W-1:0] first_pid;
  } graph_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cmd_valid = 1'b0;
  logic                                 cmd_stall;
  logic [2:0]                           mode = '0;
  logic [dagadj_pkg::RANK_W-1:0]        first_rank = '0;
  logic [dagadj_pkg::RANK_W-1:0]        second_rank = '0;
  logic [dagadj_pkg::PID_W-1:0]         node_pid = '0;
  logic                                 res_valid;
  logic                                 res_stall = 1'b0;
  logic                                 status;
  logic [dagadj_pkg::NTOT_W-1:0]        node_total;
  logic [dagadj_pkg::ETOT_W-1:0]        edge_total;
  logic [dagadj_pkg::CNT_W-1:0]         first_parents;
  logic [dagadj_pkg::CNT_W-1:0]         first_children;
  logic signed [dagadj_pkg::OPID_W-1:0] first_pid;

  dag_adjacency_degree_table uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // graph shadow state
  logic                                 slot_live     [dagadj_pkg::NODE_SLOTS];
  logic signed [dagadj_pkg::OPID_W-1:0] slot_pid      [dagadj_pkg::NODE_SLOTS];
  logic [dagadj_pkg::CNT_W-1:0]         slot_parents  [dagadj_pkg::NODE_SLOTS];
  logic [dagadj_pkg::CNT_W-1:0]         slot_children [dagadj_pkg::NODE_SLOTS];
  logic arc_live [dagadj_pkg::NODE_SLOTS][dagadj_pkg::NODE_SLOTS];
  int                                   live_nodes;
  int                                   live_arcs;

  graph_cmd_t    pending_cmds[$];
  graph_result_t expected_results[$];
  graph_cmd_t    cur_cmd;
  graph_result_t want;

  int  total_cmds    = 0;
  int  cmds_accepted = 0;
  int  results_seen  = 0;
  int  errors        = 0;
  int  node_drops    = 0;
  int  rejects_seen  = 0;
  int  peak_nodes    = 0;
  int  peak_edges    = 0;
  int  gap_left      = 0;
  int  stall_left    = 0;
  int  drv_gap_odds  = 0;
  int  rcv_stall_odds = 0;
  int  quiet_cycles  = 0;
  bit  calm_tail;

  assign calm_tail = pending_cmds.size() < CALM_TAIL;

  function automatic void clear_graph();
    for (int i = 0; i < dagadj_pkg::NODE_SLOTS; i++) begin
      slot_live[i]     = 1'b0;
      slot_pid[i]      = '1;
      slot_parents[i]  = '0;
      slot_children[i] = '0;
      for (int j = 0; j < dagadj_pkg::NODE_SLOTS; j++) arc_live[i][j] = 1'b0;
    end
    live_nodes = 0;
    live_arcs  = 0;
  endfunction

  function automatic void wake_slot(int s);
    if (!slot_live[s]) begin
      slot_live[s]     = 1'b1;
      slot_parents[s]  = '0;
      slot_children[s] = '0;
      live_nodes++;
    end
  endfunction

  function automatic graph_result_t apply_graph_op(graph_cmd_t c);
    graph_result_t r;
    int a;
    int b;
    int lo;
    int hi;
    a = c.first_rank;
    b = c.second_rank;
    r.status = dagadj_pkg::ST_DONE;
    case (c.mode)
      dagadj_pkg::OP_ADD_NODE: begin
        slot_pid[a] = {1'b0, c.pid};
        wake_slot(a);
      end
      dagadj_pkg::OP_DEL_NODE: begin
        if (slot_live[a] && live_nodes > 0) live_nodes--;
        slot_live[a]     = 1'b0;
        slot_parents[a]  = '0;
        slot_children[a] = '0;
        for (int i = 0; i < dagadj_pkg::NODE_SLOTS; i++) begin
          if (i != a) begin
            lo = (i < a) ? i : a;
            hi = (i < a) ? a : i;
            if (arc_live[lo][hi] && live_arcs > 0) begin
              live_arcs--;
              // neighbour below loses a child, neighbour above loses a parent
              if (i < a) begin
                if (slot_children[i] != 0) slot_children[i] = slot_children[i] - 1'b1;
              end else begin
                if (slot_parents[i] != 0) slot_parents[i] = slot_parents[i] - 1'b1;
              end
            end
            arc_live[lo][hi] = 1'b0;
          end
        end
      end
      dagadj_pkg::OP_ADD_EDGE, dagadj_pkg::OP_DEL_EDGE: begin
        if (a >= b) begin
          r.status = dagadj_pkg::ST_REJECT;
        end else if (c.mode == dagadj_pkg::OP_ADD_EDGE) begin
          wake_slot(a);
          wake_slot(b);
          if (!arc_live[a][b]) begin
            arc_live[a][b] = 1'b1;
            live_arcs++;
            slot_children[a] = slot_children[a] + 1'b1;
            slot_parents[b]  = slot_parents[b] + 1'b1;
          end
        end else if (arc_live[a][b]) begin
          arc_live[a][b] = 1'b0;
          if (live_arcs > 0) begin
            live_arcs--;
            if (slot_children[a] != 0) slot_children[a] = slot_children[a] - 1'b1;
            if (slot_parents[b] != 0) slot_parents[b] = slot_parents[b] - 1'b1;
          end
        end
      end
      dagadj_pkg::OP_CLEAR: clear_graph();
      default: ;
    endcase
    r.node_total     = dagadj_pkg::NTOT_W'(live_nodes);
    r.edge_total     = dagadj_pkg::ETOT_W'(live_arcs);
    r.first_parents  = slot_parents[a];
    r.first_children = slot_children[a];
    r.first_pid      = slot_pid[a];
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] m, input int a, input int b,
                           input logic [dagadj_pkg::PID_W-1:0] p);
    graph_cmd_t c;
    c.mode        = m;
    c.first_rank  = dagadj_pkg::RANK_W'(a);
    c.second_rank = dagadj_pkg::RANK_W'(b);
    c.pid         = p;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  // driver: presents pending commands, predicts on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        expected_results.push_back(apply_graph_op(cur_cmd));
        cmds_accepted++;
        if (cur_cmd.mode == dagadj_pkg::OP_DEL_NODE) node_drops++;
        if (cmds_accepted % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: drv_gap_odds = 0;
            1: drv_gap_odds = 15;
            default: drv_gap_odds = 50;
          endcase
        end
      end
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          cmd_valid <= 1'b0;
        end else if (!calm_tail && drv_gap_odds != 0 &&
                     $urandom_range(0, 99) < drv_gap_odds) begin
          gap_left = $urandom_range(1, 19) - 1;
          cmd_valid <= 1'b0;
        end else begin
          cur_cmd = pending_cmds.pop_front();
          cmd_valid   <= 1'b1;
          mode        <= cur_cmd.mode;
          first_rank  <= cur_cmd.first_rank;
          second_rank <= cur_cmd.second_rank;
          node_pid    <= cur_cmd.pid;
        end
      end
    end
  end

  // monitor: checks result beats in order, drives stall bursts
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (status == dagadj_pkg::ST_REJECT) rejects_seen++;
        if (node_total > peak_nodes) peak_nodes = node_total;
        if (edge_total > peak_edges) peak_edges = edge_total;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $error("result beat with no command outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status);
          check_field("node_total", want.node_total, node_total);
          check_field("edge_total", want.edge_total, edge_total);
          check_field("first_parents", want.first_parents, first_parents);
          check_field("first_children", want.first_children, first_children);
          check_field("first_pid", want.first_pid, first_pid);
        end
        if (results_seen % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: rcv_stall_odds = 0;
            1: rcv_stall_odds = 3;
            default: rcv_stall_odds = 12;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (!res_stall && !calm_tail && rcv_stall_odds != 0 &&
                   $urandom_range(0, 99) < rcv_stall_odds) begin
        stall_left = $urandom_range(1, 19) - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dag_adjacency_degree_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [2*dagadj_pkg::RANK_W-1:0] pairs[$];
    logic [2*dagadj_pkg::RANK_W-1:0] tmp;
    logic [dagadj_pkg::PID_W-1:0]    pid;
    int                              a;
    int                              b;
    int                              k;
    int                              roll;
    int                              base;
    bit                              narrow;

    clear_graph();

    // directed: field extremes, every operation, the corner behaviors
    queue_cmd(dagadj_pkg::OP_ADD_NODE, 0, 0, '0);
    queue_cmd(dagadj_pkg::OP_ADD_NODE, dagadj_pkg::NODE_SLOTS - 1,
              dagadj_pkg::NODE_SLOTS - 1, '1);
    queue_cmd(dagadj_pkg::OP_ADD_NODE, 0, 17, 22'h155555);     // pid overwrite on live slot
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 0, dagadj_pkg::NODE_SLOTS - 1, 22'h2AAAAA);
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 0, dagadj_pkg::NODE_SLOTS - 1, '0); // already present
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 10, 21, '0);            // both ends wake, pid stays -1
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 21, 10, '0);            // reversed order
    queue_cmd(dagadj_pkg::OP_DEL_EDGE, 7, 7, '0);              // equal ranks
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 0, 21, '0);
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 10, dagadj_pkg::NODE_SLOTS - 1, '0);
    queue_cmd(dagadj_pkg::OP_DEL_EDGE, 0, dagadj_pkg::NODE_SLOTS - 1, '0);
    queue_cmd(dagadj_pkg::OP_DEL_EDGE, 0, dagadj_pkg::NODE_SLOTS - 1, '0); // already gone
    queue_cmd(dagadj_pkg::OP_DEL_NODE, 21, 0, '0);             // drops both its edges, keeps pid
    queue_cmd(dagadj_pkg::OP_DEL_NODE, 21, 0, '0);             // dead slot
    queue_cmd(dagadj_pkg::OP_ADD_NODE, 21, 30, 22'h2AAAAA);
    queue_cmd(OP_SPARE_FIRST, 10, 31, '1);
    queue_cmd(OP_SPARE_FIRST + 3'd1, dagadj_pkg::NODE_SLOTS - 1, 0, '0);
    queue_cmd(OP_SPARE_LAST, 0, 0, 22'h3F0F0F);
    queue_cmd(dagadj_pkg::OP_DEL_EDGE, 3, 9, '0);              // dead ends, no edge
    queue_cmd(dagadj_pkg::OP_CLEAR, 10, 0, '0);
    queue_cmd(dagadj_pkg::OP_ADD_EDGE, 30, dagadj_pkg::NODE_SLOTS - 1, '0);
    queue_cmd(dagadj_pkg::OP_ADD_NODE, 30, 0, 22'h0000FF);
    queue_cmd(dagadj_pkg::OP_DEL_NODE, dagadj_pkg::NODE_SLOTS - 1, 0, '0);
    queue_cmd(dagadj_pkg::OP_CLEAR, 0, dagadj_pkg::NODE_SLOTS - 1, '1);

    // complete graph in shuffled order: drives totals and counts to their ceilings
    for (int i = 0; i < dagadj_pkg::NODE_SLOTS; i++)
      for (int j = i + 1; j < dagadj_pkg::NODE_SLOTS; j++)
        pairs.push_back({dagadj_pkg::RANK_W'(i), dagadj_pkg::RANK_W'(j)});
    for (int i = pairs.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = pairs[i];
      pairs[i] = pairs[k];
      pairs[k] = tmp;
    end
    foreach (pairs[i])
      queue_cmd(dagadj_pkg::OP_ADD_EDGE, pairs[i][2*dagadj_pkg::RANK_W-1:dagadj_pkg::RANK_W],
                pairs[i][dagadj_pkg::RANK_W-1:0], dagadj_pkg::PID_W'($urandom));
    queue_cmd(dagadj_pkg::OP_ADD_NODE, dagadj_pkg::NODE_SLOTS - 1, 0,
              dagadj_pkg::PID_W'($urandom));
    queue_cmd(dagadj_pkg::OP_DEL_NODE, dagadj_pkg::NODE_SLOTS - 1, 0, '0);
    queue_cmd(dagadj_pkg::OP_DEL_NODE, 0, 0, '0);

    // random mix, mostly within a narrow window of slots so edges pile up
    narrow = 1'b1;
    base = 0;
    for (int n = 0; n < MIX_CMDS; n++) begin
      if (n % 40 == 0) begin
        narrow = ($urandom_range(0, 9) < 7);
        base = $urandom_range(0, dagadj_pkg::NODE_SLOTS - 8);
      end
      a = narrow ? base + $urandom_range(0, 7) : $urandom_range(0, dagadj_pkg::NODE_SLOTS - 1);
      b = narrow ? base + $urandom_range(0, 7) : $urandom_range(0, dagadj_pkg::NODE_SLOTS - 1);
      pid = ($urandom_range(0, 15) == 0) ? '1 : dagadj_pkg::PID_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        queue_cmd(dagadj_pkg::OP_ADD_NODE, a, b, pid);
      end else if (roll < 32) begin
        queue_cmd(dagadj_pkg::OP_DEL_NODE, a, b, pid);
      end else if (roll < 82) begin
        if (a == b) b = (a == dagadj_pkg::NODE_SLOTS - 1) ? a - 1 : a + 1;
        if (a > b) begin
          k = a;
          a = b;
          b = k;
        end
        queue_cmd((roll < 62) ? dagadj_pkg::OP_ADD_EDGE : dagadj_pkg::OP_DEL_EDGE, a, b, pid);
      end else if (roll < 88) begin
        // malformed edge request: first rank not below second
        if (a < b) begin
          k = a;
          a = b;
          b = k;
        end
        if (roll == 82) b = a;
        queue_cmd(roll[0] ? dagadj_pkg::OP_ADD_EDGE : dagadj_pkg::OP_DEL_EDGE, a, b, pid);
      end else if (roll < 92) begin
        queue_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), a, b, pid);
      end else if (roll < 94) begin
        queue_cmd(dagadj_pkg::OP_CLEAR, a, b, pid);
      end else begin
        queue_cmd(dagadj_pkg::OP_ADD_NODE, a, b, roll[0] ? '0 : '1);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmds_accepted < total_cmds || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      errors++;
      $error("%0d expected results never arrived", expected_results.size());
    end
    $display("%0d commands (%0d node removals), %0d results checked, %0d edge rejects",
             cmds_accepted, node_drops, results_seen, rejects_seen);
    $display("peak totals seen: %0d nodes, %0d edges; %0d mismatches",
             peak_nodes, peak_edges, errors);
    if (errors == 0)
      $display("dag_adjacency_degree_table regression: pass");
    else
      $display("dag_adjacency_degree_table regression: fail");
    $finish;
  end

endmodule

/* sim.f */
design/dagadj_pkg.sv
design/dag_adjacency_degree_table.sv
verif/dag_adjacency_degree_table_tb.sv
